// File: sv/iiel_pkg.sv
// Shared constants, codes and types for the indexed insert/erase list.
package iiel_pkg;

	localparam int CAPACITY    = 32;
	localparam int MAX_RESULTS = 32;
	localparam int VAL_W       = 32;
	localparam int POS_W       = 6;
	localparam int OP_W        = 2;
	localparam int ST_W        = 2;
	localparam int COUNT_W     = 6;
	localparam int IDX_W       = 5;
	localparam int IN_W        = 40;
	localparam int OUT_W       = 48;
	localparam int OUT_PAD_W   = OUT_W - (ST_W + COUNT_W + IDX_W + VAL_W);

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_ERASE  = 2'd1,
		OP_DUMP   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		STATUS_OK     = 2'd0,
		STATUS_BADPOS = 2'd1,
		STATUS_FULL   = 2'd2,
		STATUS_RSVD   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_ERASE,
		CELL_ROTATE
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t          cmd;
		logic [POS_W-1:0]   pos;
		logic [COUNT_W-1:0] tail;
		logic [VAL_W-1:0]   new_val;
	} cell_ctrl_t;

endpackage

// File: sv/iiel_cell.sv
// One list cell: holds an entry and takes a neighbor's value on insert, erase or rotate.
module iiel_cell (
	input  logic                        clk,
	input  iiel_pkg::cell_ctrl_t        ctrl,
	input  logic [iiel_pkg::COUNT_W-1:0] cell_idx,
	input  logic [iiel_pkg::VAL_W-1:0]  prev_val,
	input  logic [iiel_pkg::VAL_W-1:0]  next_val,
	input  logic [iiel_pkg::VAL_W-1:0]  head_val,
	output logic [iiel_pkg::VAL_W-1:0]  value
);
	import iiel_pkg::*;

	logic [VAL_W-1:0] value_q;
	logic [VAL_W-1:0] value_d;
	logic [COUNT_W-1:0] pos_ext;

	assign pos_ext = COUNT_W'(ctrl.pos);

	always_comb begin
		value_d = value_q;
		unique case (ctrl.cmd)
			CELL_HOLD: value_d = value_q;
			CELL_INSERT: begin
				if (cell_idx > pos_ext) begin
					value_d = prev_val;
				end else if (cell_idx == pos_ext) begin
					value_d = ctrl.new_val;
				end
			end
			CELL_ERASE: begin
				if (cell_idx >= pos_ext) begin
					value_d = next_val;
				end
			end
			CELL_ROTATE: begin
				if (cell_idx == ctrl.tail) begin
					value_d = head_val;
				end else if (cell_idx < ctrl.tail) begin
					value_d = next_val;
				end
			end
			default: value_d = value_q;
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value = value_q;

endmodule

// File: sv/indexed_insert_erase_list.sv
// Top level of the indexed insert/erase list built as a chain of entry cells.
//
// Usage:
//   Input channel s_*: one transfer per command (insert, erase, dump).
//   Output channel m_*: one result per insert, erase or unknown command;
//   a dump returns one result per stored entry in list order with tlast on
//   the final one, or a single empty result when the list holds nothing.
//   Insert and erase shift the cells in the cycle the command is taken, so
//   their result is registered with the input transfer and a new
//   command can be taken every cycle while the receiver keeps up.
//   A dump of N entries enters a dump state after the command and then
//   rotates the cell chain one place per result while the output is free;
//   s_tready stays low until the last entry has left the output register.
//   After the rotation the chain is back in its original order.
//   When the receiver stalls, the output register holds its result and a
//   new command is taken only once that result is transferred or taken
//   in the same cycle.
//   Reset clears the entry count and drops the output valid; entry contents
//   are not cleared and are read only after being written.
module indexed_insert_erase_list_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// s_tdata: opcode[1:0], position[7:2], item_value[39:8]
	input  logic [iiel_pkg::IN_W-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// m_tdata: status[1:0], count[7:2], entry_index[12:8], entry_value[44:13], zero pad
	output logic [iiel_pkg::OUT_W-1:0]  m_tdata,
	// m_tuser: entry_valid[0]
	output logic                        m_tuser,
	output logic                        m_tlast
);
	import iiel_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

	state_t             state_q;
	logic [COUNT_W-1:0] count_q;
	logic [IDX_W-1:0]   dump_idx_q;
	logic               m_tvalid_q;
	logic [ST_W-1:0]    status_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               entry_valid_q;
	logic [IDX_W-1:0]   entry_index_q;
	logic [VAL_W-1:0]   entry_value_q;
	logic               last_q;

	op_t                in_op;
	logic [POS_W-1:0]   in_pos;
	logic [VAL_W-1:0]   in_val;
	logic               out_free;
	logic               in_accept;
	cell_ctrl_t         ctrl;
	logic [COUNT_W-1:0] tail;
	logic               dump_last;
	logic               ins_ok;
	logic               ins_badpos;
	logic               era_ok;
	logic [COUNT_W-1:0] count_d;
	status_t            in_status;

	logic [VAL_W-1:0] cell_val [CAPACITY];

	assign in_op  = op_t'(s_tdata[OP_W-1:0]);
	assign in_pos = s_tdata[OP_W +: POS_W];
	assign in_val = s_tdata[OP_W+POS_W +: VAL_W];

	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) && out_free;
	assign in_accept = s_tvalid && s_tready;

	assign tail       = count_q - COUNT_W'(1);
	assign dump_last  = (COUNT_W'(dump_idx_q) == tail);
	assign ins_badpos = (COUNT_W'(in_pos) > count_q);
	assign ins_ok     = !ins_badpos && (count_q != COUNT_W'(CAPACITY));
	assign era_ok     = (COUNT_W'(in_pos) < count_q);

	always_comb begin
		count_d   = count_q;
		in_status = STATUS_OK;
		unique case (in_op)
			OP_INSERT: begin
				if (ins_badpos) begin
					in_status = STATUS_BADPOS;
				end else if (!ins_ok) begin
					in_status = STATUS_FULL;
				end else begin
					count_d = count_q + COUNT_W'(1);
				end
			end
			OP_ERASE: begin
				if (!era_ok) begin
					in_status = STATUS_BADPOS;
				end else begin
					count_d = count_q - COUNT_W'(1);
				end
			end
			OP_DUMP: in_status = STATUS_OK;
			OP_NONE: in_status = STATUS_BADPOS;
			default: in_status = STATUS_BADPOS;
		endcase
	end

	always_comb begin
		ctrl.cmd     = CELL_HOLD;
		ctrl.pos     = in_pos;
		ctrl.tail    = tail;
		ctrl.new_val = in_val;
		if (in_accept) begin
			if (in_op == OP_INSERT && ins_ok) begin
				ctrl.cmd = CELL_INSERT;
			end else if (in_op == OP_ERASE && era_ok) begin
				ctrl.cmd = CELL_ERASE;
			end
		end else if (state_q == ST_DUMP && out_free) begin
			ctrl.cmd = CELL_ROTATE;
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [VAL_W-1:0] prev_v;
		logic [VAL_W-1:0] next_v;
		if (g == 0) begin : g_first
			assign prev_v = '0;
		end else begin : g_mid_p
			assign prev_v = cell_val[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign next_v = '0;
		end else begin : g_mid_n
			assign next_v = cell_val[g+1];
		end
		iiel_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.cell_idx (COUNT_W'(g)),
			.prev_val (prev_v),
			.next_val (next_v),
			.head_val (cell_val[0]),
			.value    (cell_val[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			dump_idx_q    <= '0;
			m_tvalid_q    <= 1'b0;
			status_q      <= STATUS_OK;
			out_count_q   <= '0;
			entry_valid_q <= 1'b0;
			entry_index_q <= '0;
			entry_value_q <= '0;
			last_q        <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						entry_valid_q <= 1'b0;
						entry_index_q <= '0;
						entry_value_q <= '0;
						last_q        <= 1'b1;
						count_q       <= count_d;
						out_count_q   <= count_d;
						status_q      <= in_status;
						if (in_op == OP_DUMP && count_q != '0) begin
							m_tvalid_q <= 1'b0;
							dump_idx_q <= '0;
							state_q    <= ST_DUMP;
						end else begin
							m_tvalid_q <= 1'b1;
						end
					end else if (m_tready) begin
						m_tvalid_q <= 1'b0;
					end
				end
				ST_DUMP: begin
					if (out_free) begin
						m_tvalid_q    <= 1'b1;
						status_q      <= STATUS_OK;
						out_count_q   <= count_q;
						entry_valid_q <= 1'b1;
						entry_index_q <= dump_idx_q;
						entry_value_q <= cell_val[0];
						last_q        <= dump_last;
						dump_idx_q    <= dump_idx_q + IDX_W'(1);
						if (dump_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {OUT_PAD_W'(0), entry_value_q, entry_index_q, out_count_q, status_q};
	assign m_tuser  = entry_valid_q;
	assign m_tlast  = last_q;

endmodule

// File: sv/iiel_checker.sv
// Port-level checks for the indexed insert/erase list, bound to the top level.
module iiel_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [iiel_pkg::OUT_W-1:0]  m_tdata,
	input logic                        m_tuser,
	input logic                        m_tlast
);
	import iiel_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	a_no_take_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("non-entry result without last");

	a_entry_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[ST_W-1:0] == STATUS_OK)
		else $error("dump entry with bad status");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[ST_W +: COUNT_W] <= COUNT_W'(CAPACITY))
		else $error("count above capacity");

endmodule

bind indexed_insert_erase_list_core iiel_checker u_iiel_checker (.*);

// File: verif/list_tb_pkg.sv
// Scoreboard with a list predictor for the indexed insert/erase list testbench.
package list_tb_pkg;
	import iiel_pkg::*;

	typedef struct {
		status_t            status;
		logic [COUNT_W-1:0] count;
		logic               entry_valid;
		logic [IDX_W-1:0]   entry_index;
		logic [VAL_W-1:0]   entry_value;
		logic               last;
	} list_result_t;

	class list_scoreboard;
		logic [VAL_W-1:0] contents[$];
		list_result_t     awaited[$];
		int               errors;
		int               commands;
		int               results;
		int               refusals;
		int               dumps;

		function int length();
			return contents.size();
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void push_result(status_t st, logic valid, int idx, logic [VAL_W-1:0] val,
			logic last);
			list_result_t r;
			r.status      = st;
			r.count       = COUNT_W'(contents.size());
			r.entry_valid = valid;
			r.entry_index = IDX_W'(idx);
			r.entry_value = val;
			r.last        = last;
			awaited.push_back(r);
		endfunction

		function void note_command(op_t op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
			int n;
			commands++;
			case (op)
				OP_INSERT: begin
					if (int'(pos) > contents.size()) begin
						push_result(STATUS_BADPOS, 1'b0, 0, '0, 1'b1);
					end else if (contents.size() >= CAPACITY) begin
						refusals++;
						push_result(STATUS_FULL, 1'b0, 0, '0, 1'b1);
					end else begin
						contents.insert(int'(pos), val);
						push_result(STATUS_OK, 1'b0, 0, '0, 1'b1);
					end
				end
				OP_ERASE: begin
					if (int'(pos) >= contents.size()) begin
						push_result(STATUS_BADPOS, 1'b0, 0, '0, 1'b1);
					end else begin
						contents.delete(int'(pos));
						push_result(STATUS_OK, 1'b0, 0, '0, 1'b1);
					end
				end
				OP_DUMP: begin
					dumps++;
					n = (contents.size() > MAX_RESULTS) ? MAX_RESULTS : contents.size();
					if (n == 0)
						push_result(STATUS_OK, 1'b0, 0, '0, 1'b1);
					for (int i = 0; i < n; i++)
						push_result(STATUS_OK, 1'b1, i, contents[i], i + 1 == n);
				end
				default: begin
					push_result(STATUS_BADPOS, 1'b0, 0, '0, 1'b1);
				end
			endcase
		endfunction

		task report(string field, longint exp_v, longint got_v);
			errors++;
			if (errors <= 40)
				$display("mismatch on result %0d: %s expected %0h got %0h",
					results, field, exp_v, got_v);
		endtask

		task check_result(logic [OUT_W-1:0] data, logic user, logic tlast);
			list_result_t e;
			results++;
			if (awaited.size() == 0) begin
				report("unexpected transfer", 0, data);
				return;
			end
			e = awaited.pop_front();
			if (data[ST_W-1:0] !== e.status)
				report("status", e.status, data[ST_W-1:0]);
			if (data[ST_W +: COUNT_W] !== e.count)
				report("count", e.count, data[ST_W +: COUNT_W]);
			if (data[ST_W+COUNT_W +: IDX_W] !== e.entry_index)
				report("entry_index", e.entry_index, data[ST_W+COUNT_W +: IDX_W]);
			if (data[ST_W+COUNT_W+IDX_W +: VAL_W] !== e.entry_value)
				report("entry_value", e.entry_value, data[ST_W+COUNT_W+IDX_W +: VAL_W]);
			if (data[OUT_W-1 -: OUT_PAD_W] !== '0)
				report("pad", 0, data[OUT_W-1 -: OUT_PAD_W]);
			if (user !== e.entry_valid)
				report("entry_valid", e.entry_valid, user);
			if (tlast !== e.last)
				report("last", e.last, tlast);
		endtask
	endclass

endpackage

// File: verif/tb_top.sv
// Top-level testbench for the indexed insert/erase list core.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import iiel_pkg::*;
	import list_tb_pkg::*;

	localparam int TIMEOUT_CYCLES = 400000;

	logic              clk;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata  = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;
	logic              m_tuser;
	logic              m_tlast;

	list_scoreboard board = new;
	int             max_gap = 7;
	int             max_stall = 7;
	int             cycles = 0;

	indexed_insert_erase_list_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > TIMEOUT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_cmd(op_t op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {val, pos, op};
		do @(posedge clk); while (!s_tready);
		board.note_command(op, pos, val);
	endtask

	function automatic logic [VAL_W-1:0] rand_word();
		case ($urandom_range(0, 11))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [POS_W-1:0] pick_pos(op_t op);
		int len;
		int sel;
		len = board.length();
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return POS_W'($urandom_range(0, 63));
		if (sel == 1)
			return POS_W'((op == OP_ERASE) ? len : len + 1);
		if (op == OP_ERASE)
			return POS_W'((len == 0) ? 0 : $urandom_range(0, len - 1));
		return POS_W'($urandom_range(0, len));
	endfunction

	task automatic random_cmd(int w_ins, int w_era, int w_dump);
		int  roll;
		op_t op;
		roll = $urandom_range(0, 99);
		if (roll < w_ins)
			op = OP_INSERT;
		else if (roll < w_ins + w_era)
			op = OP_ERASE;
		else if (roll < w_ins + w_era + w_dump)
			op = OP_DUMP;
		else
			op = OP_NONE;
		send_cmd(op, pick_pos(op), rand_word());
	endtask

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, max_stall);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			board.check_result(m_tdata, m_tuser, m_tlast);
		end
	end

	initial begin
		int steps;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(OP_DUMP, 6'd0, 32'h0);
		send_cmd(OP_ERASE, 6'd0, 32'hffff_ffff);
		send_cmd(OP_INSERT, 6'd1, 32'h1234_5678);
		send_cmd(OP_INSERT, 6'd0, 32'h7fff_ffff);
		send_cmd(OP_INSERT, 6'd0, 32'h8000_0000);
		send_cmd(OP_INSERT, 6'd2, 32'hffff_ffff);
		send_cmd(OP_INSERT, 6'd1, 32'h0000_0000);
		send_cmd(OP_INSERT, 6'd63, 32'h5555_5555);
		send_cmd(OP_NONE, 6'd63, 32'haaaa_aaaa);
		send_cmd(OP_DUMP, 6'd42, 32'hdead_beef);
		send_cmd(OP_ERASE, 6'd4, 32'h0);
		send_cmd(OP_ERASE, 6'd3, 32'h0);
		send_cmd(OP_ERASE, 6'd0, 32'h0);
		send_cmd(OP_ERASE, 6'd32, 32'h0);
		send_cmd(OP_DUMP, 6'd0, 32'h0);
		send_cmd(OP_ERASE, 6'd0, 32'h0);
		send_cmd(OP_ERASE, 6'd0, 32'h0);
		send_cmd(OP_DUMP, 6'd0, 32'h0);

		// fill toward capacity back to back, mostly with inserts
		max_gap   = 0;
		max_stall = 0;
		steps = 0;
		while (board.length() < CAPACITY && steps < 80) begin
			random_cmd(90, 3, 4);
			steps++;
		end

		max_gap   = 7;
		max_stall = 7;
		repeat (6) random_cmd(100, 0, 0);

		// hold until the output side has drained
		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		send_cmd(OP_DUMP, pick_pos(OP_DUMP), rand_word());

		max_gap = 3;
		repeat (12) random_cmd(35, 35, 20);

		max_gap   = 7;
		max_stall = 0;
		steps = 0;
		while (board.length() > 0 && steps < 25) begin
			random_cmd(5, 80, 10);
			steps++;
		end

		max_stall = 7;
		repeat (5) random_cmd(40, 30, 20);

		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("ran %0d commands (%0d dumps), checked %0d results, %0d full refusals",
			board.commands, board.dumps, board.results, board.refusals);
		$display("%0d field mismatches", board.errors);
		if (board.errors == 0 && board.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: sim.f
sv/iiel_pkg.sv
sv/iiel_cell.sv
sv/indexed_insert_erase_list.sv
sv/iiel_checker.sv
verif/list_tb_pkg.sv
verif/tb_top.sv
